// ===== design/sorted_priority_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_assert
// assertion macros for the sorted priority queue, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("spq assertion failed");

`define SPQ_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT(label, clk, rstn, prop)
`define SPQ_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] rank;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts down on insert and up
// on removal
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               prev_gt,
    input  spq_pkg::entry_t    prev_entry,
    input  spq_pkg::entry_t    succ_entry,
    output logic               gt,
    output spq_pkg::entry_t    entry,
    output spq_pkg::entry_t    entry_next
);
    import spq_pkg::*;

    entry_t entry_reg;

    // empty slots count as greater so a new entry lands at the tail
    assign gt    = !occupied || (entry_reg.rank > ctrl.new_entry.rank);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq && gt) begin
            entry_next = prev_gt ? prev_entry : ctrl.new_entry;
        end else if (ctrl.deq) begin
            entry_next = succ_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// bounded priority queue kept sorted by rank in a chain of slot cells
// ----------------------------------------------------------------------------
// s_ channel: one transfer per item, s_action selects enqueue of
// (s_item_value, s_item_rank) or dequeue of the head entry.
// m_ channel: one result transfer per item showing the queue afterwards:
// head entry (zero when empty), head_valid, entry count and a drop flag
// set when an enqueue met a full queue.
// every slot compares its rank with the incoming one in parallel, then each
// cell takes its own entry, its neighbour's or the new one, and the result
// is registered: it appears on m_ in the cycle after the input transfer, and
// one item per cycle is sustained while the receiver keeps taking results.
// the result sits in an output register; a new item is taken whenever that
// register is empty or being read in the same cycle, so a stalled receiver
// holds the result and stops s_ready until it is taken.
// equal ranks are served in arrival order.
// reset (aresetn low, synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic signed [spq_pkg::DATA_W-1:0] s_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] s_item_rank,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_head_valid,
    output logic signed [spq_pkg::DATA_W-1:0] m_head_value,
    output logic signed [spq_pkg::DATA_W-1:0] m_head_rank,
    output logic [spq_pkg::OUT_CNT_W-1:0]     m_entry_count,
    output logic                              m_dropped
);
    import spq_pkg::*;

    count_t     count_reg, count_next;
    logic       m_valid_reg;
    logic       head_valid_reg;
    entry_t     head_reg, head_next;
    logic [OUT_CNT_W-1:0] cnt_out_reg;
    logic       dropped_reg, dropped_next;
    logic       s_fire, full;
    cell_ctrl_t ctrl;

    logic   [CAPACITY-1:0] occ;
    logic   [CAPACITY-1:0] gt;
    entry_t                cell_q    [CAPACITY];
    entry_t                cell_next [CAPACITY];
    logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        ctrl.new_entry.value = s_item_value;
        ctrl.new_entry.rank  = s_item_rank;
        ctrl.enq = s_fire && (s_action == ACT_ENQ) && !full;
        ctrl.deq = s_fire && (s_action == ACT_DEQ) && (count_reg != '0);
        dropped_next = (s_action == ACT_ENQ) && full;
        count_next = count_reg;
        if (ctrl.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.deq) begin
            count_next = count_reg - CNT_W'(1);
        end
        head_next = (count_next != '0) ? cell_next[0] : '0;
    end

    assign cnt_wide = {{OUT_CNT_W{1'b0}}, count_next};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign occ[i] = (CNT_W'(i) < count_reg);

        spq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occ[i]),
            .prev_gt    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
            .prev_entry (cell_q[(i == 0) ? 0 : i-1]),
            .succ_entry ((i == CAPACITY-1) ? '0 : cell_q[(i == CAPACITY-1) ? i : i+1]),
            .gt         (gt[i]),
            .entry      (cell_q[i]),
            .entry_next (cell_next[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            head_valid_reg <= (count_next != '0);
            head_reg       <= head_next;
            cnt_out_reg    <= cnt_wide[OUT_CNT_W-1:0];
            dropped_reg    <= dropped_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_head_valid  = head_valid_reg;
    assign m_head_value  = head_reg.value;
    assign m_head_rank   = head_reg.rank;
    assign m_entry_count = cnt_out_reg;
    assign m_dropped     = dropped_reg;

    `SPQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT(a_drop_when_full, aclk, aresetn, (m_valid && m_dropped) |-> full)
    `SPQ_ASSERT(a_head_sorted, aclk, aresetn, occ[1] |-> (cell_q[1].rank >= cell_q[0].rank))
    `SPQ_ASSERT_NEXT(a_enq_grows, aclk, aresetn, ctrl.enq, count_reg == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_entry_count))

endmodule
